[hdl/jvx_pkg.sv]
package jvx_pkg;

  localparam int unsigned KeyLen = 10;

  typedef enum logic [3:0] {
    PH_KEY        = 4'd0,
    PH_SKIP_ONE   = 4'd1,
    PH_AFTER_KEY  = 4'd2,
    PH_STAR_QUOTE = 4'd3,
    PH_STAR       = 4'd4,
    PH_AFTER_STAR = 4'd5,
    PH_VALUE_OPEN = 4'd6,
    PH_VALUE      = 4'd7,
    PH_ESCAPE     = 4'd8,
    PH_HEX        = 4'd9,
    PH_DONE       = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  localparam logic [15:0] LimitReset = 16'd4096;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  key_pos;
    logic [15:0] hex_acc;
    logic [2:0]  hex_cnt;
    logic [15:0] line_len;
    logic        line_nl;
  } state_t;

  // "wikitext" with its quotes
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h22;
      4'd1:    ch = 8'h77;
      4'd2:    ch = 8'h69;
      4'd3:    ch = 8'h6B;
      4'd4:    ch = 8'h69;
      4'd5:    ch = 8'h74;
      4'd6:    ch = 8'h65;
      4'd7:    ch = 8'h78;
      4'd8:    ch = 8'h74;
      4'd9:    ch = 8'h22;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[hdl/jvx_decode.sv]
module jvx_decode import jvx_pkg::*; (
  input  state_t      st_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] limit_i,
  output state_t      st_o,
  output res_t [2:0]  res_o,
  output logic [1:0]  res_cnt_o
);

  typedef struct packed {
    res_t [2:0]  res;
    logic [1:0]  cnt;
    logic [15:0] len;
    logic        nl;
  } acc_t;

  function automatic acc_t f_push(input acc_t a, input kind_e k, input logic [7:0] d);
    acc_t r;
    r = a;
    if (a.cnt != 2'd3) begin
      r.res[a.cnt].kind = k;
      r.res[a.cnt].data = d;
      r.res[a.cnt].last = 1'b0;
      r.cnt = a.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic acc_t f_emit(input acc_t a, input logic [7:0] d);
    acc_t r;
    r = f_push(a, KIND_BYTE, d);
    if (a.len != 16'hFFFF) r.len = a.len + 16'd1;
    if (d == 8'h0A) r.nl = 1'b1;
    return r;
  endfunction

  function automatic acc_t f_eol(input acc_t a);
    acc_t r;
    r = f_push(a, KIND_EOL, 8'h00);
    r.len = 16'd0;
    r.nl = 1'b0;
    return r;
  endfunction

  function automatic acc_t f_code(input acc_t a, input logic [15:0] v);
    acc_t r;
    r = a;
    if (v < 16'h0080) begin
      r = f_emit(r, v[7:0]);
    end else if (v < 16'h0800) begin
      r = f_emit(r, {3'b110, v[10:6]});
      r = f_emit(r, {2'b10, v[5:0]});
    end else if (v < 16'hD800 || v > 16'hDFFF) begin
      r = f_emit(r, {4'hE, v[15:12]});
      r = f_emit(r, {2'b10, v[11:6]});
      r = f_emit(r, {2'b10, v[5:0]});
    end else begin
      r = f_emit(r, 8'hEF);
      r = f_emit(r, 8'hBF);
      r = f_emit(r, 8'hBD);
    end
    return r;
  endfunction

  acc_t        acc;
  state_t      st;
  logic [7:0]  lc;
  logic        is_dig;
  logic [3:0]  dig;
  logic [15:0] acc_hex;
  logic [16:0] grown;

  always_comb begin
    st        = st_i;
    acc       = '0;
    acc.len   = st_i.line_len;
    acc.nl    = st_i.line_nl;
    lc        = byte_i | 8'h20;
    is_dig    = 1'b1;
    dig       = 4'd0;
    acc_hex   = '0;
    grown     = {1'b0, st_i.line_len} + 17'd1;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      dig = byte_i[3:0];
    end else if (lc >= 8'h61 && lc <= 8'h66) begin
      dig = lc[3:0] + 4'd9;
    end else begin
      is_dig = 1'b0;
    end

    unique case (st_i.phase)
      PH_KEY: begin
        if (st_i.key_pos < 4'(KeyLen) && byte_i == key_char(st_i.key_pos)) begin
          st.key_pos = st_i.key_pos + 4'd1;
          if (st.key_pos == 4'(KeyLen)) st.phase = PH_SKIP_ONE;
        end else begin
          st.key_pos = (byte_i == 8'h22) ? 4'd1 : 4'd0;
        end
      end
      PH_SKIP_ONE: st.phase = PH_AFTER_KEY;
      PH_AFTER_KEY: if (byte_i == 8'h7B) st.phase = PH_STAR_QUOTE;
      PH_STAR_QUOTE: if (byte_i == 8'h22) st.phase = PH_STAR;
      PH_STAR: st.phase = (byte_i == 8'h2A) ? PH_AFTER_STAR : PH_STAR_QUOTE;
      PH_AFTER_STAR: if (byte_i == 8'h3A) st.phase = PH_VALUE_OPEN;
      PH_VALUE_OPEN: if (byte_i == 8'h22) st.phase = PH_VALUE;
      PH_VALUE: begin
        if (byte_i == 8'h5C) begin
          st.phase = PH_ESCAPE;
        end else if (byte_i == 8'h22) begin
          if (st_i.line_len != 16'd0) acc = f_eol(acc);
          acc = f_push(acc, KIND_DONE, 8'h00);
          st.phase = PH_DONE;
        end else begin
          acc = f_emit(acc, byte_i);
          if (grown > {1'b0, limit_i} && !acc.nl) acc = f_eol(acc);
        end
      end
      PH_ESCAPE: begin
        st.phase = PH_VALUE;
        if (byte_i == 8'h6E) begin
          acc = f_eol(acc);
        end else if (byte_i == 8'h74) begin
          acc = f_emit(acc, 8'h20);
        end else if (byte_i == 8'h72) begin
          acc = acc;
        end else if (byte_i == 8'h75) begin
          st.hex_acc = '0;
          st.hex_cnt = '0;
          st.phase   = PH_HEX;
        end else begin
          acc = f_emit(acc, byte_i);
        end
      end
      PH_HEX: begin
        acc_hex = {st_i.hex_acc[11:0], dig};
        if (is_dig && st_i.hex_cnt < 3'd3) begin
          st.hex_acc = acc_hex;
          st.hex_cnt = st_i.hex_cnt + 3'd1;
        end else begin
          acc = f_code(acc, is_dig ? acc_hex : st_i.hex_acc);
          st.hex_acc = '0;
          st.hex_cnt = '0;
          st.phase   = PH_VALUE;
        end
      end
      default: st.phase = PH_DONE;
    endcase

    if (acc.cnt != 2'd0) acc.res[acc.cnt - 2'd1].last = 1'b1;
    st.line_len = acc.len;
    st.line_nl  = acc.nl;
  end

  assign st_o      = st;
  assign res_o     = acc.res;
  assign res_cnt_o = acc.cnt;

endmodule

[hdl/jvx_resbuf.sv]
module jvx_resbuf import jvx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t [2:0] res_i,
  input  logic [1:0] cnt_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output res_t       res_o
);

  res_t [2:0] res_q, res_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && ready_i);
  assign res_o   = res_q[idx_q];

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      res_d = res_i;
      cnt_d = cnt_i;
      idx_d = 2'd0;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

[hdl/json_value_extract_unescape_core.sv]
// JSON value extractor and unescaper.
// Input: s_axis stream, one JSON byte per word. The block hunts for the
// "wikitext" key and its "*" member, then streams the quoted value with
// escapes decoded (\uXXXX to UTF-8) and overlong raw lines broken.
// Output: m_axis stream, one result per word. tuser carries the kind
// (byte, line end, value complete), tdata the decoded byte, and tlast marks
// the final result caused by one input byte.
// Config: cfg_valid_i/cfg_ready_o/cfg_data_i write the 16-bit line limit;
// write it only while the block is idle. cfg_ready_o is always high.
// Path: a byte waits in the input register until the result buffer has room,
// and its results are then registered in the result buffer that drives m_axis.
// Throughput: one byte per cycle while each byte yields at most one result
// and m_axis_tready is high; a byte with n results (up to 3, from \u escapes
// or forced line ends) holds the input until its last result is being sent.
// Reset: phase goes back to key search, line limit to 4096, buffers empty.
// Stall: when m_axis_tready is low the result buffer holds and the input
// register fills, then s_axis_tready drops; nothing is lost.
module json_value_extract_unescape_core import jvx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_byte_q;
  logic [15:0] limit_q, limit_d;
  state_t      st_q, st_d;
  res_t [2:0]  dec_res;
  logic [1:0]  dec_cnt;
  logic        room;
  logic        process;
  logic        accept;
  res_t        out_res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !in_vld_q || room;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign process       = in_vld_q && room;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) in_vld_d = 1'b1;
    else if (process) in_vld_d = 1'b0;
    limit_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : limit_q;
  end

  jvx_decode u_decode (
    .st_i      (st_q),
    .byte_i    (in_byte_q),
    .limit_i   (limit_q),
    .st_o      (st_d),
    .res_o     (dec_res),
    .res_cnt_o (dec_cnt)
  );

  jvx_resbuf u_resbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (process),
    .res_i   (dec_res),
    .cnt_i   (dec_cnt),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      limit_q  <= LimitReset;
      st_q     <= '{phase: PH_KEY, default: '0};
    end else begin
      in_vld_q <= in_vld_d;
      limit_q  <= limit_d;
      if (process) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_byte_q <= s_axis_tdata;
  end

endmodule

[hdl/jvx_checker.sv]
module jvx_checker import jvx_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_BYTE || m_axis_tuser == KIND_EOL
      || m_axis_tuser == KIND_DONE))
    else $error("bad result kind");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_BYTE) |-> m_axis_tdata == 8'h00)
    else $error("nonzero data on marker word");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
    else $error("completion word without tlast");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_DONE) |=> !m_axis_tvalid)
    else $error("output after completion");

endmodule

bind json_value_extract_unescape_core jvx_checker u_jvx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
